// ===== rtl/gme_pkg.sv =====
package gme_pkg;

    // Fixed field widths of the result item and the configuration register.
    localparam int VALUE_W     = 36;
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 4;
    localparam int OUT_TDATA_W = 48;

    // Tag that travels beside each multiply-accumulate through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_mac_ctl;

endpackage

// ===== rtl/gme_store.sv =====
module gme_store
    import gme_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0]        o_rd_data_a,
    output logic [DATA_W-1:0]        o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two read ports with registered data; the data holds while reads are disabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/gme_seq.sv =====
module gme_seq
    import gme_pkg::*;
#(
    parameter int MAX_N = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    output logic                             o_wr_en,
    output logic [$clog2(MAX_N*MAX_N)-1:0]   o_wr_addr,
    input  logic                             i_adv,
    output logic [$clog2(MAX_N*MAX_N)-1:0]   o_rd_addr_a,
    output logic [$clog2(MAX_N*MAX_N)-1:0]   o_rd_addr_b,
    output t_mac_ctl                         o_ctl
);

    localparam int AW = $clog2(MAX_N*MAX_N);
    localparam int NW = $clog2(MAX_N+1);
    localparam int TW = $clog2(MAX_N*MAX_N+1);
    localparam int IW = $clog2(MAX_N);

    localparam logic STATE_LOAD = 1'b0;
    localparam logic STATE_CALC = 1'b1;

    logic          r_state;
    logic [NW-1:0] r_n;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_load_cnt;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_c;
    logic [IW-1:0] r_r;
    logic [AW-1:0] r_base_r;
    logic [AW-1:0] r_base_c;

    logic [NW-1:0] n_n;
    logic [NW-1:0] n_last_idx;
    logic          accept;
    logic          issue;
    logic          k_end;
    logic          c_end;
    logic          r_end;

    // Clamp the written count to the supported range.
    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_n = NW'(1);
        end else if (i_cfg_data > CFG_W'(MAX_N)) begin
            n_n = NW'(MAX_N);
        end else begin
            n_n = i_cfg_data[NW-1:0];
        end
    end

    assign n_last_idx = r_n - NW'(1);
    assign accept     = i_in_valid && (r_state == STATE_LOAD);
    assign issue      = (r_state == STATE_CALC) && i_adv;
    assign k_end      = (NW'(r_k) == n_last_idx);
    assign c_end      = (NW'(r_c) == n_last_idx);
    assign r_end      = (NW'(r_r) == n_last_idx);

    // Load phase fills the store; compute phase walks rows, columns and the inner index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= STATE_LOAD;
            r_n        <= NW'(MAX_N);
            r_total    <= TW'(MAX_N*MAX_N);
            r_load_cnt <= '0;
            r_k        <= '0;
            r_c        <= '0;
            r_r        <= '0;
            r_base_r   <= '0;
            r_base_c   <= '0;
        end else if (i_cfg_valid) begin
            r_n        <= n_n;
            r_total    <= TW'(n_n * n_n);
            r_load_cnt <= '0;
            r_state    <= STATE_LOAD;
        end else if (accept) begin
            if (r_load_cnt + TW'(1) == r_total) begin
                r_load_cnt <= '0;
                r_state    <= STATE_CALC;
                r_k        <= '0;
                r_c        <= '0;
                r_r        <= '0;
                r_base_r   <= '0;
                r_base_c   <= '0;
            end else begin
                r_load_cnt <= r_load_cnt + TW'(1);
            end
        end else if (issue) begin
            if (!k_end) begin
                r_k <= r_k + IW'(1);
            end else begin
                r_k <= '0;
                if (!c_end) begin
                    r_c      <= r_c + IW'(1);
                    r_base_c <= r_base_c + AW'(r_n);
                end else begin
                    r_c      <= '0;
                    r_base_c <= '0;
                    if (!r_end) begin
                        r_r      <= r_r + IW'(1);
                        r_base_r <= r_base_r + AW'(r_n);
                    end else begin
                        r_state <= STATE_LOAD;
                    end
                end
            end
        end
    end

    assign o_in_ready  = (r_state == STATE_LOAD);
    assign o_wr_en     = accept;
    assign o_wr_addr   = r_load_cnt[AW-1:0];
    assign o_rd_addr_a = r_base_r + AW'(r_k);
    assign o_rd_addr_b = r_base_c + AW'(r_k);

    // Tag of the access issued this cycle.
    always_comb begin
        o_ctl.valid = (r_state == STATE_CALC);
        o_ctl.first = (r_k == '0);
        o_ctl.lastk = k_end;
        o_ctl.last  = k_end && c_end && r_end;
        o_ctl.row   = IDX_W'(r_r);
        o_ctl.col   = IDX_W'(r_c);
    end

endmodule

// ===== rtl/gme_mac.sv =====
module gme_mac
    import gme_pkg::*;
#(
    parameter int MAX_N  = 8,
    parameter int ELEM_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  logic [ELEM_W-1:0]  i_a,
    input  logic [ELEM_W-1:0]  i_b,
    output logic               o_adv,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_value,
    output logic [IDX_W-1:0]   o_row,
    output logic [IDX_W-1:0]   o_col,
    output logic               o_last
);

    localparam int PROD_W = 2*ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_N) + 1;
    localparam int SUM_W  = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;

    t_mac_ctl            r_tag1;
    t_mac_ctl            r_tag2;
    logic [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]    r_acc;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [IDX_W-1:0]    r_out_row;
    logic [IDX_W-1:0]    r_out_col;
    logic                r_out_last;

    logic [SUM_W-1:0]    n_sum;
    logic                adv;
    logic                emit;

    // The whole pipeline freezes while a finished entry waits at the output.
    assign adv  = !r_out_valid || i_ready;
    assign emit = adv && r_tag2.valid && r_tag2.lastk;

    // Tags follow the read data and the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else if (adv) begin
            r_tag1 <= i_ctl;
            r_tag2 <= r_tag1;
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= PROD_W'($signed(i_a) * $signed(i_b));
        end
    end

    // Accumulate; the first term of an entry restarts the sum.
    assign n_sum = (r_tag2.first ? '0 : r_acc)
                 + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (adv && r_tag2.valid) begin
            r_acc <= n_sum;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= n_sum[VALUE_W-1:0];
            r_out_row   <= r_tag2.row;
            r_out_col   <= r_tag2.col;
            r_out_last  <= r_tag2.last;
        end
    end

    assign o_adv   = adv;
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/gram_matrix_engine_unit.sv =====
// Gram matrix engine.
// The input stream carries one signed Q8.8 element per transfer in vector-major
// order: element k of vector i is the (i*N+k)-th transfer of a load. N comes from
// the configuration channel (0 acts as 1, values above MAX_N act as MAX_N); a
// write restarts the load; the user must make it only while the block is idle;
// the block does not enforce this. After the N*N-th element the block stops
// taking input and computes all N*N dot products with one multiply-accumulate
// unit fed by a two-read-port vector store. The output stream carries each
// entry as signed Q20.16 with its row and column, in row-major order, with
// tlast on entry (N-1,N-1). Loading takes one element per cycle; store read
// pairs are issued one per cycle while the output is not stalled.
// Input is taken again once the last store read of the matrix has been issued.
// When the receiver stalls, the output register holds its entry and the store
// reads, the multiplier and the accumulator freeze until it is taken.
// Reset empties the pipeline, sets N to MAX_N and clears the load count; the
// store contents are not cleared and need no clearing pass.
module gram_matrix_engine_unit
    import gme_pkg::*;
#(
    parameter int MAX_N         = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration channel: vector count.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_W-1:0]                      i_cfg_data,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // element
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,  // product_value, row, col
    output logic                                  m_axis_tlast
);

    localparam int DEPTH = MAX_N*MAX_N;
    localparam int AW    = $clog2(DEPTH);

    t_mac_ctl                seq_ctl;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic [ELEMENT_WIDTH-1:0] rd_data_a;
    logic [ELEMENT_WIDTH-1:0] rd_data_b;
    logic                    adv;
    logic [VALUE_W-1:0]      out_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;

    // Sequencer: loading and the row, column and inner-index walk.
    gme_seq #(
        .MAX_N (MAX_N)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .i_adv       (adv),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_ctl       (seq_ctl)
    );

    // Vector store.
    gme_store #(
        .DEPTH  (DEPTH),
        .DATA_W (ELEMENT_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (s_axis_tdata[ELEMENT_WIDTH-1:0]),
        .i_rd_en     (adv),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Multiply-accumulate and output register.
    gme_mac #(
        .MAX_N  (MAX_N),
        .ELEM_W (ELEMENT_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .i_a     (rd_data_a),
        .i_b     (rd_data_b),
        .o_adv   (adv),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (out_value),
        .o_row   (out_row),
        .o_col   (out_col),
        .o_last  (m_axis_tlast)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {{(OUT_TDATA_W-VALUE_W-2*IDX_W){1'b0}}, out_col, out_row, out_value};

    // The final entry of a matrix lies on the diagonal.
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_row == out_col))
        else $error("last entry off the diagonal");

    // No element is written while store reads are being issued.
    a_no_load_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.valid |-> !wr_en)
        else $error("store write during compute");

    // Issuing the final read of a matrix reopens the input.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctl.valid && seq_ctl.last && adv && !i_cfg_valid) |=> s_axis_tready)
        else $error("input not reopened after compute");

endmodule

// ===== dv/tb_gram_matrix_engine_unit.sv =====
module tb_gram_matrix_engine_unit;
    import gme_pkg::*;

    localparam int MAX_N       = 8;
    localparam int STORE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 380;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 2 * MAX_N + 4;

    // One Gram entry as the output stream carries it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic                      last;
    } t_gram_entry;

    typedef enum logic {ROW_CFG, ROW_ELEM} t_row_kind;

    // A directed step: a vector count write or one element, optionally with
    // the value that every entry of the finished matrix must carry.
    typedef struct packed {
        t_row_kind                 kind;
        logic [15:0]               value;
        logic                      fixed;
        logic signed [VALUE_W-1:0] fixed_value;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;     // element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // product_value, row, col
    logic                   m_axis_tlast;

    // Predictor state: the loaded elements, the load position and N.
    logic [15:0]      elem_store [STORE_DEPTH];
    int               elems_loaded = 0;
    logic [CFG_W-1:0] count_reg = 4'd8;

    t_gram_entry expected_entries [$];
    int          mismatch_count = 0;
    int          entries_seen = 0;

    // Random idling is switched off during the calm stretch; the long hold
    // of the receiver is armed once by the stimulus.
    bit calm_stretch = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    t_stim_row directed_rows [20] = '{
        '{ROW_CFG,  16'd1,     1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b1, 36'sd1073741824},
        '{ROW_ELEM, 16'h7FFF,  1'b1, 36'sd1073676289},
        '{ROW_ELEM, 16'h0000,  1'b1, 36'sd0},
        '{ROW_ELEM, 16'hFFFF,  1'b1, 36'sd1},
        '{ROW_CFG,  16'd0,     1'b0, 36'sd0},
        '{ROW_ELEM, 16'h0100,  1'b1, 36'sd65536},
        '{ROW_CFG,  16'd15,    1'b0, 36'sd0},
        '{ROW_ELEM, 16'h1234,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h4321,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'hABCD,  1'b0, 36'sd0},
        '{ROW_CFG,  16'd2,     1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b1, 36'sd2147483648},
        '{ROW_ELEM, 16'h7FFF,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h8000,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'h0001,  1'b0, 36'sd0},
        '{ROW_ELEM, 16'hFFFF,  1'b0, 36'sd0}
    };

    gram_matrix_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The register value 0 acts as one vector, values above MAX_N as MAX_N.
    function automatic int active_dim();
        int n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > MAX_N) n = MAX_N;
        return n;
    endfunction

    // Store one element; when the load is complete, queue the whole matrix.
    function automatic void absorb_element(logic [15:0] e, logic fixed,
                                           logic signed [VALUE_W-1:0] fixed_value);
        int n;
        int r;
        int c;
        int k;
        longint acc;
        t_gram_entry ent;
        n = active_dim();
        elem_store[elems_loaded % STORE_DEPTH] = e;
        elems_loaded = (elems_loaded + 1) % 128;
        if (elems_loaded < n * n) return;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                acc = 0;
                for (k = 0; k < n; k++) begin
                    acc += longint'($signed(elem_store[r * n + k]))
                         * longint'($signed(elem_store[c * n + k]));
                end
                ent.value = fixed ? fixed_value : acc[VALUE_W-1:0];
                ent.row   = IDX_W'(r);
                ent.col   = IDX_W'(c);
                ent.last  = (r == n - 1) && (c == n - 1);
                expected_entries.push_back(ent);
            end
        end
        elems_loaded = 0;
    endfunction

    // Mostly random bit patterns, with the extremes and small values mixed in.
    function automatic logic [15:0] pick_element();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            3: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Write N only once the block has drained and settled.
    task automatic write_vector_count(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg    = v;
        elems_loaded = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one element, with a random gap in front, until it is transferred.
    task automatic send_element(input logic [15:0] e, input logic fixed,
                                input logic signed [VALUE_W-1:0] fixed_value);
        int gap;
        gap = (!calm_stretch && $urandom_range(99) < 14) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_element(e, fixed, fixed_value);
    endtask

    // Receiver: random stalls, and one long hold while the sender keeps going.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request && !hold_done && m_axis_tvalid) begin
            m_axis_tready <= 1'b0;
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end else begin
            m_axis_tready <= calm_stretch || ($urandom_range(99) >= 14);
        end
    end

    // Compare each transferred entry with the oldest expected one.
    always @(posedge i_clk) begin
        t_gram_entry want;
        logic signed [VALUE_W-1:0] got_value;
        logic [IDX_W-1:0] got_row;
        logic [IDX_W-1:0] got_col;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_value = m_axis_tdata[VALUE_W-1:0];
            got_row   = m_axis_tdata[VALUE_W +: IDX_W];
            got_col   = m_axis_tdata[VALUE_W + IDX_W +: IDX_W];
            entries_seen++;
            if (expected_entries.size() == 0) begin
                $error("unexpected entry: product_value %0d row %0d col %0d last %0b",
                       got_value, got_row, got_col, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_entries.pop_front();
                if (got_value !== want.value) begin
                    $error("product_value: expected %0d, got %0d", want.value, got_value);
                    mismatch_count++;
                end
                if (got_row !== want.row) begin
                    $error("row: expected %0d, got %0d", want.row, got_row);
                    mismatch_count++;
                end
                if (got_col !== want.col) begin
                    $error("col: expected %0d, got %0d", want.col, got_col);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then phases of full loads at varied N, now and then followed by a partial load.
    initial begin
        int sent;
        int phase;
        int setting;
        int loads;
        int n;
        int l;
        int e;
        sent  = 0;
        phase = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_vector_count(directed_rows[i].value[CFG_W-1:0]);
            end else begin
                send_element(directed_rows[i].value, directed_rows[i].fixed,
                             directed_rows[i].fixed_value);
            end
        end

        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin setting = 3;  loads = 4; end
                1: begin setting = 8;  loads = 1; end
                2: begin setting = 1;  loads = 6; end
                3: begin setting = 15; loads = 2; end
                4: begin setting = 0;  loads = 5; end
                default: begin
                    setting = ($urandom_range(9) < 6) ? $urandom_range(1, 4)
                                                      : $urandom_range(0, 15);
                    loads = 0;
                end
            endcase
            write_vector_count(CFG_W'(setting));
            n = active_dim();
            if (loads == 0) loads = (n >= 6) ? 1 : $urandom_range(1, 4);
            hold_request = (phase == 0);
            calm_stretch = (phase == 3);
            for (l = 0; l < loads; l++) begin
                for (e = 0; e < n * n; e++) begin
                    send_element(pick_element(), 1'b0, '0);
                    sent++;
                end
            end
            // Now and then leave a load unfinished; the next write restarts it.
            if (phase >= 5 && n > 1 && $urandom_range(5) == 0) begin
                repeat ($urandom_range(1, n * n - 1)) begin
                    send_element(pick_element(), 1'b0, '0);
                    sent++;
                end
            end
            calm_stretch = 1'b0;
            phase++;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_entries.size() != 0) @(posedge i_clk);
        repeat (4 * MAX_N + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(8 * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
